// File: src/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared codes, result record and helpers for the maze backtracking carver.
// ----------------------------------------------------------------------------
package mbc_pkg;

  // Item actions; any other code reads a cell
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;

  // Directions, clockwise from north
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Offset from a direction to its opposite (half the direction count)
  localparam logic [1:0] DIR_HALF = 2'd2;

  // Cell memory word: visited flag over four passage bits
  localparam int CELL_W  = 5;
  localparam int VIS_BIT = 4;

  localparam logic [3:0] ALL_TRIED = 4'hF;

  // Side length after reset
  localparam logic [5:0] SIDE_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_CARVED    = 3'd1,
    ST_RETRY     = 3'd2,
    ST_BACKTRACK = 3'd3,
    ST_FINISHED  = 3'd4,
    ST_READ_DONE = 3'd5,
    ST_BAD_COORD = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NBR,
    S_TOP,
    S_POP,
    S_READ
  } ctrl_state_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] row;
    logic [4:0] col;
    logic [1:0] dir;
    logic [3:0] open_sides;
    logic       empty;
  } res_t;

  function automatic logic [3:0] dir_bit(input logic [1:0] d);
    dir_bit = 4'b0001 << d;
  endfunction

  function automatic res_t mk_res(input status_t st, input logic [4:0] r,
                                  input logic [4:0] c, input logic [1:0] d,
                                  input logic [3:0] op, input logic em);
    res_t t;
    t.status     = st;
    t.row        = r;
    t.col        = c;
    t.dir        = d;
    t.open_sides = op;
    t.empty      = em;
    mk_res = t;
  endfunction

endpackage

// File: src/mbc_ifs.sv
// ----------------------------------------------------------------------------
// mbc_ifs
// Valid/ready channels of the maze carver: command items, result items and
// the side length write port.
// ----------------------------------------------------------------------------
interface mbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] direction_draw;
  logic [4:0] cell_row;
  logic [4:0] cell_col;

  modport source(output valid, action, direction_draw, cell_row, cell_col,
                 input ready);
  modport sink(input valid, action, direction_draw, cell_row, cell_col,
               output ready);
endinterface

interface mbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] result_row;
  logic [4:0] result_col;
  logic [1:0] carved_direction;
  logic [3:0] open_passages;
  logic       stack_empty;

  modport source(output valid, status, result_row, result_col, carved_direction,
                 open_passages, stack_empty, input ready);
  modport sink(input valid, status, result_row, result_col, carved_direction,
               open_passages, stack_empty, output ready);
endinterface

interface mbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] side_length;

  modport source(output valid, side_length, input ready);
  modport sink(input valid, side_length, output ready);
endinterface

// File: src/mbc_ram.sv
// ----------------------------------------------------------------------------
// mbc_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbc_ram #(
  parameter int WIDTH  = 5,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:(1 << ADDR_W) - 1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/mbc_ctrl.sv
// ----------------------------------------------------------------------------
// mbc_ctrl
// Carving sequencer: decodes items, runs the cell memory read-modify-write,
// pushes and pops the path stack and sweeps the cell memory clear.
// ----------------------------------------------------------------------------
module mbc_ctrl import mbc_pkg::*; #(
  parameter int CW = 5,
  parameter int GW = 7
) (
  input  logic              clk,
  input  logic              rst,
  mbc_in_if.sink            cmd,
  input  logic [GW-1:0]     grid_n,
  input  logic              slot_free,
  output logic              res_valid,
  output res_t              res,
  output logic              cm_we,
  output logic [2*CW-1:0]   cm_waddr,
  output logic [CELL_W-1:0] cm_wdata,
  output logic [2*CW-1:0]   cm_raddr,
  input  logic [CELL_W-1:0] cm_rdata,
  output logic              st_we,
  output logic [2*CW-1:0]   st_waddr,
  output logic [2*CW-1:0]   st_wdata,
  output logic [2*CW-1:0]   st_raddr,
  input  logic [2*CW-1:0]   st_rdata
);

  localparam int AW = 2 * CW;
  localparam int DW = AW + 1;

  ctrl_state_t   state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [AW-1:0] top_cell, top_next;
  logic [DW-1:0] depth, depth_next;
  logic [3:0]    tried, tried_next;
  logic [1:0]    dir_q, dir_next;
  logic [AW-1:0] addr_q, addr_next;

  logic          cmd_acc;
  logic [AW-1:0] cmd_addr;
  logic          cmd_in_grid;
  logic [CW-1:0] top_r, top_c;
  logic [GW-1:0] nr_g, nc_g;
  logic          nbr_ok;
  logic [AW-1:0] nbr_addr;
  logic [3:0]    tried_draw;
  logic [DW-1:0] depth_dec;
  logic          vis_hit;
  logic [1:0]    opp_dir;
  logic          fail;
  logic [3:0]    fail_mask;

  // Accept only when idle and the result slot is free
  assign cmd.ready = (state == S_IDLE) && slot_free;
  assign cmd_acc   = cmd.valid && cmd.ready;

  assign cmd_addr    = {CW'(cmd.cell_row), CW'(cmd.cell_col)};
  assign cmd_in_grid = (GW'(cmd.cell_row) < grid_n) && (GW'(cmd.cell_col) < grid_n);

  assign top_r      = top_cell[AW-1:CW];
  assign top_c      = top_cell[CW-1:0];
  assign tried_draw = tried | dir_bit(cmd.direction_draw);
  assign depth_dec  = depth - DW'(1);
  assign vis_hit    = cm_rdata[VIS_BIT];
  assign opp_dir    = dir_q + DIR_HALF;

  // Step from the stack top toward the drawn direction
  always_comb begin
    nr_g = GW'(top_r);
    nc_g = GW'(top_c);
    case (cmd.direction_draw)
      DIR_N:   nr_g = GW'(top_r) - GW'(1);
      DIR_E:   nc_g = GW'(top_c) + GW'(1);
      DIR_S:   nr_g = GW'(top_r) + GW'(1);
      DIR_W:   nc_g = GW'(top_c) - GW'(1);
      default: nr_g = GW'(top_r);
    endcase
  end

  assign nbr_ok   = (nr_g < grid_n) && (nc_g < grid_n);
  assign nbr_addr = {nr_g[CW-1:0], nc_g[CW-1:0]};

  // State and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      depth    <= '0;
      tried    <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      depth    <= depth_next;
      tried    <= tried_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_cell <= top_next;
    dir_q    <= dir_next;
    addr_q   <= addr_next;
  end

  // Next state, memory accesses and results
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    top_next      = top_cell;
    depth_next    = depth;
    tried_next    = tried;
    dir_next      = dir_q;
    addr_next     = addr_q;
    res_valid     = 1'b0;
    res           = mk_res(ST_STARTED, 5'd0, 5'd0, 2'd0, 4'd0, 1'b0);
    cm_we         = 1'b0;
    cm_waddr      = clr_addr;
    cm_wdata      = '0;
    cm_raddr      = cmd_addr;
    st_we         = 1'b0;
    st_waddr      = depth[AW-1:0];
    st_wdata      = addr_q;
    st_raddr      = AW'(depth - DW'(2));
    fail          = 1'b0;
    fail_mask     = tried;

    case (state)
      // Sweep the cell memory; mark the start cell once a path exists
      S_CLEAR: begin
        cm_we         = 1'b1;
        cm_waddr      = clr_addr;
        cm_wdata      = {(depth != '0) && (clr_addr == top_cell), 4'b0000};
        clr_addr_next = clr_addr + AW'(1);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_acc) begin
          case (cmd.action)
            ACT_START: begin
              res_valid = 1'b1;
              if (!cmd_in_grid) begin
                res = mk_res(ST_BAD_COORD, cmd.cell_row, cmd.cell_col, 2'd0, 4'd0,
                             depth == '0);
              end else begin
                top_next      = cmd_addr;
                depth_next    = DW'(1);
                tried_next    = '0;
                st_we         = 1'b1;
                st_waddr      = '0;
                st_wdata      = cmd_addr;
                clr_addr_next = '0;
                state_next    = S_CLEAR;
                res = mk_res(ST_STARTED, cmd.cell_row, cmd.cell_col, 2'd0, 4'd0, 1'b0);
              end
            end
            ACT_DRAW: begin
              if (depth == '0) begin
                res_valid = 1'b1;
                res = mk_res(ST_FINISHED, 5'd0, 5'd0, 2'd0, 4'd0, 1'b1);
              end else begin
                tried_next = tried_draw;
                dir_next   = cmd.direction_draw;
                if (nbr_ok) begin
                  cm_raddr   = nbr_addr;
                  addr_next  = nbr_addr;
                  state_next = S_NBR;
                end else begin
                  fail      = 1'b1;
                  fail_mask = tried_draw;
                end
              end
            end
            default: begin
              if (!cmd_in_grid) begin
                res_valid = 1'b1;
                res = mk_res(ST_BAD_COORD, cmd.cell_row, cmd.cell_col, 2'd0, 4'd0,
                             depth == '0);
              end else begin
                cm_raddr   = cmd_addr;
                addr_next  = cmd_addr;
                state_next = S_READ;
              end
            end
          endcase
        end
      end

      // Neighbor word is back: if unvisited, open its side, push it and fetch the top word; else fail the draw
      S_NBR: begin
        state_next = S_IDLE;
        if (vis_hit) begin
          fail      = 1'b1;
          fail_mask = tried;
        end else begin
          cm_we      = 1'b1;
          cm_waddr   = addr_q;
          cm_wdata   = {1'b1, cm_rdata[3:0] | dir_bit(opp_dir)};
          cm_raddr   = top_cell;
          st_we      = 1'b1;
          st_waddr   = depth[AW-1:0];
          st_wdata   = addr_q;
          state_next = S_TOP;
        end
      end

      // Open the top cell's side and advance onto the new cell
      S_TOP: begin
        cm_we      = 1'b1;
        cm_waddr   = top_cell;
        cm_wdata   = {1'b1, cm_rdata[3:0] | dir_bit(dir_q)};
        top_next   = addr_q;
        depth_next = depth + DW'(1);
        tried_next = '0;
        res_valid  = 1'b1;
        res = mk_res(ST_CARVED, 5'(addr_q[AW-1:CW]), 5'(addr_q[CW-1:0]), dir_q,
                     4'd0, 1'b0);
        state_next = S_IDLE;
      end

      // Load the new stack top after a pop
      S_POP: begin
        top_next   = st_rdata;
        state_next = S_IDLE;
      end

      S_READ: begin
        res_valid  = 1'b1;
        res = mk_res(ST_READ_DONE, 5'(addr_q[AW-1:CW]), 5'(addr_q[CW-1:0]), 2'd0,
                     cm_rdata[3:0], depth == '0);
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Failed draw: pop once every direction is tried, else retry
    if (fail) begin
      res_valid = 1'b1;
      if (fail_mask == ALL_TRIED) begin
        depth_next = depth_dec;
        tried_next = '0;
        res = mk_res(ST_BACKTRACK, 5'(top_r), 5'(top_c), 2'd0, 4'd0,
                     depth_dec == '0);
        if (depth_dec != '0) begin
          st_raddr   = AW'(depth - DW'(2));
          state_next = S_POP;
        end
      end else begin
        res = mk_res(ST_RETRY, 5'(top_r), 5'(top_c), 2'd0, 4'd0, 1'b0);
      end
    end
  end

  // No items while the cell memory is being swept
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("item accepted during clear sweep");

  // Neighbor write and top read never hit the same entry
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_NBR && !vis_hit) |-> (addr_q != top_cell))
    else $error("carve writes the stack top entry");

  // A carve pushes exactly one cell and clears the tried set
  a_carve_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP) |=> (depth == $past(depth) + DW'(1)) && (tried == '0))
    else $error("carve did not push");

  // A pop always follows a backtrack that left cells on the stack
  a_pop_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(state) == S_IDLE || $past(state) == S_NBR) &&
                         (depth != '0))
    else $error("stray pop");

endmodule

// File: src/maze_backtracker_carver.sv
// ----------------------------------------------------------------------------
// maze_backtracker_carver
// Depth-first backtracking maze carver over a square grid of cells.
// Results: start, finished, bad coordinate and a draw toward the grid edge give
//   their result from the idle state; read, and a retry or backtrack on a
//   visited neighbor, after the memory read; carve after S_NBR and S_TOP.
// One item at a time: a carve holds the input through S_NBR and S_TOP, a read
//   through S_READ, a draw that finds a visited neighbor through S_NBR, a
//   backtrack with cells left also through S_POP for the stack read.
// A start sweeps all (2**$clog2(MAX_SIDE))**2 cell memory entries (1024 at
//   MAX_SIDE 32); reset runs the same sweep before the first item.
// ----------------------------------------------------------------------------
module maze_backtracker_carver import mbc_pkg::*; #(
  parameter int MAX_SIDE = 32
) (
  input  logic      clk,
  input  logic      rst,
  mbc_in_if.sink    cmd,
  mbc_out_if.source rsp,
  mbc_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int GW = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int AW = 2 * CW;

  logic [5:0]        side_length;
  logic [GW-1:0]     grid_n;
  logic              res_valid;
  res_t              res;
  logic              out_valid, pend_valid;
  res_t              out_q, pend_q;
  logic              out_free;

  logic              cm_we;
  logic [AW-1:0]     cm_waddr, cm_raddr;
  logic [CELL_W-1:0] cm_wdata, cm_rdata;
  logic              st_we;
  logic [AW-1:0]     st_waddr, st_wdata, st_raddr, st_rdata;

  // Side length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_RESET;
    end else if (cfg.valid) begin
      side_length <= cfg.side_length;
    end
  end

  // Clamp side length into the supported grid
  always_comb begin
    if (side_length == 6'd0) begin
      grid_n = GW'(1);
    end else if (GW'(side_length) > GW'(MAX_SIDE)) begin
      grid_n = GW'(MAX_SIDE);
    end else begin
      grid_n = GW'(side_length);
    end
  end

  // Output register with one pending slot behind it
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= pend_valid || res_valid;
      pend_valid <= pend_valid && res_valid;
    end else if (res_valid) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= pend_valid ? pend_q : res;
      if (pend_valid && res_valid) begin
        pend_q <= res;
      end
    end else if (res_valid) begin
      pend_q <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_q.status;
  assign rsp.result_row       = out_q.row;
  assign rsp.result_col       = out_q.col;
  assign rsp.carved_direction = out_q.dir;
  assign rsp.open_passages    = out_q.open_sides;
  assign rsp.stack_empty      = out_q.empty;

  mbc_ctrl #(
    .CW(CW),
    .GW(GW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .grid_n   (grid_n),
    .slot_free(!pend_valid),
    .res_valid(res_valid),
    .res      (res),
    .cm_we    (cm_we),
    .cm_waddr (cm_waddr),
    .cm_wdata (cm_wdata),
    .cm_raddr (cm_raddr),
    .cm_rdata (cm_rdata),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata)
  );

  // Visited flag and passages per cell
  mbc_ram #(
    .WIDTH (CELL_W),
    .ADDR_W(AW)
  ) u_cell_mem (
    .clk  (clk),
    .we   (cm_we),
    .waddr(cm_waddr),
    .wdata(cm_wdata),
    .raddr(cm_raddr),
    .rdata(cm_rdata)
  );

  // Path stack of cell addresses
  mbc_ram #(
    .WIDTH (AW),
    .ADDR_W(AW)
  ) u_stack_mem (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

endmodule
